// ===== sv/stks_pkg.sv =====
// Shared types, constants and compare helpers for the top-k selector.
`timescale 1ns / 1ps
package stks_pkg;
	localparam int MaxK = 64;
	localparam int KW = 7;
	localparam int IdxW = 6;
	localparam int IdW = 18;
	localparam int ScW = 16;

	typedef struct packed {
		logic [15:0] logit_bits;
		logic        row_end;
	} in_beat_t;

	typedef struct packed {
		logic [17:0] token_id;
		logic [15:0] score_bits;
		logic        rank_last;
		logic        short_row;
	} out_beat_t;

	typedef enum logic [0:0] {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	// New value and its column, broadcast along the chain.
	typedef struct packed {
		logic [ScW-1:0] score;
		logic [IdW-1:0] id;
	} bcast_t;

	function automatic logic bf_nan(input logic [15:0] x);
		return x[14:0] > 15'h7F80;
	endfunction

	function automatic logic [15:0] bf_key(input logic [15:0] x);
		return x[15] ? ~x : (x | 16'h8000);
	endfunction

	function automatic logic bf_gt(input logic [15:0] a, input logic [15:0] b);
		if (bf_nan(a) || bf_nan(b)) return 1'b0;
		if (a[14:0] == 15'd0 && b[14:0] == 15'd0) return 1'b0;
		return bf_key(a) > bf_key(b);
	endfunction
endpackage

// ===== sv/stks_cell.sv =====
// One insertion cell: holds a kept entry and trades it with its neighbours.
`timescale 1ns / 1ps
module stks_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,       // this cell holds a live entry
	input  logic               take_new,    // load the broadcast value
	input  logic               take_prev,   // shift: take the entry above
	input  logic               take_next,   // drain: take the entry below
	input  stks_pkg::bcast_t   bc,
	input  logic [15:0]        prev_score,
	input  logic [17:0]        prev_id,
	input  logic [15:0]        next_score,
	input  logic [17:0]        next_id,
	output logic               gt,          // new value beats this cell
	output logic [15:0]        score,
	output logic [17:0]        id
);
	logic [15:0] score_q;
	logic [17:0] id_q;

	assign gt    = valid && stks_pkg::bf_gt(bc.score, score_q);
	assign score = score_q;
	assign id    = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= 16'd0;
			id_q    <= 18'd0;
		end else if (take_next) begin
			score_q <= next_score;
			id_q    <= next_id;
		end else if (take_new) begin
			score_q <= bc.score;
			id_q    <= bc.id;
		end else if (take_prev) begin
			score_q <= prev_score;
			id_q    <= prev_id;
		end
	end
endmodule

// ===== sv/streaming_top_k_select_core.sv =====
// Top level: streaming top-k selector built as a chain of insertion cells.
// The first result of a row appears in the cycle after its row_end beat is taken,
// and the rest follow one per cycle as the sink takes them.
// Throughput: one logit per cycle while collecting; a row drain of n entries
// occupies n output beats, with input held off until the last one is taken.
// Reset: arst_n clears the count, column counter, drain state and cells, sets top_k to 1.
`timescale 1ns / 1ps
module streaming_top_k_select_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  stks_pkg::in_beat_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output stks_pkg::out_beat_t   out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [0:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	localparam int N = stks_pkg::MaxK;

	logic [6:0]  top_k_q;
	logic [6:0]  count_q;
	logic [17:0] col_q;
	logic        short_q;
	stks_pkg::state_t state_q, state_d;

	// APB: a single register at byte address 0 (word offset 0 of paddr).
	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {25'd0, top_k_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= 7'd1;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			top_k_q <= pwdata[6:0];
		end
	end

	// Effective limit: zero reads as one, above 64 saturates.
	logic [6:0] k_eff;
	always_comb begin
		if (top_k_q == 7'd0) k_eff = 7'd1;
		else if (top_k_q > 7'(N)) k_eff = 7'(N);
		else k_eff = top_k_q;
	end

	logic take;
	assign in_ready = (state_q == stks_pkg::ST_COLLECT);
	assign take     = in_valid && in_ready;

	// Live count after trimming to the current limit.
	logic [6:0] cnt_t;
	assign cnt_t = (count_q > k_eff) ? k_eff : count_q;

	logic [N-1:0]  cvalid, cgt, above, tk_new, tk_prev;
	logic [15:0]   csc [N];
	logic [17:0]   cid [N];
	logic [15:0]   up_sc [N];
	logic [17:0]   up_id [N];
	logic [15:0]   dn_sc [N];
	logic [17:0]   dn_id [N];
	logic          any_gt;
	logic          drain_shift;
	stks_pkg::bcast_t bc;

	assign bc.score = in_data.logit_bits;
	assign bc.id    = col_q;
	assign any_gt   = |cgt;

	assign drain_shift = (state_q == stks_pkg::ST_DRAIN) && out_ready;

	// Count after an insertion: grows by one while room remains.
	logic [6:0] cnt_next;
	assign cnt_next = (cnt_t < k_eff && (any_gt || cnt_t < k_eff)) ? cnt_t + 7'd1 : cnt_t;

	// The new value lands at the first live cell it beats, or is appended at the
	// end while room remains; every cell below the landing point shifts down one.
	always_comb begin
		above[0] = 1'b0;
		for (int i = 1; i < N; i++) above[i] = above[i-1] | cgt[i-1];
		up_sc[0] = csc[0];
		up_id[0] = cid[0];
		for (int i = 1; i < N; i++) begin
			up_sc[i] = csc[i-1];
			up_id[i] = cid[i-1];
		end
		dn_sc[N-1] = csc[N-1];
		dn_id[N-1] = cid[N-1];
		for (int i = 0; i < N - 1; i++) begin
			dn_sc[i] = csc[i+1];
			dn_id[i] = cid[i+1];
		end
		for (int i = 0; i < N; i++) begin
			cvalid[i]  = (7'(i) < cnt_t);
			tk_new[i]  = take && ((cgt[i] && !above[i]) ||
				(!any_gt && 7'(i) == cnt_t && cnt_t < k_eff));
			tk_prev[i] = take && above[i] && (7'(i) < cnt_next);
		end
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			stks_cell u_cell (
				.clk(clk), .arst_n(arst_n), .valid(cvalid[g]),
				.take_new(tk_new[g]), .take_prev(tk_prev[g]), .take_next(drain_shift),
				.bc(bc),
				.prev_score(up_sc[g]), .prev_id(up_id[g]),
				.next_score(dn_sc[g]), .next_id(dn_id[g]),
				.gt(cgt[g]), .score(csc[g]), .id(cid[g])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		case (state_q)
			stks_pkg::ST_COLLECT: if (take && in_data.row_end) state_d = stks_pkg::ST_DRAIN;
			stks_pkg::ST_DRAIN:   if (out_ready && count_q == 7'd1) state_d = stks_pkg::ST_COLLECT;
			default:              state_d = stks_pkg::ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stks_pkg::ST_COLLECT;
			count_q <= 7'd0;
			col_q   <= 18'd0;
			short_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				count_q <= cnt_next;
				col_q   <= in_data.row_end ? 18'd0 : col_q + 18'd1;
				short_q <= cnt_next < k_eff;
			end else if (drain_shift) begin
				count_q <= count_q - 7'd1;
			end
		end
	end

	// The head cell presents the current result; drain pops it toward the sink.
	assign out_valid           = (state_q == stks_pkg::ST_DRAIN);
	assign out_data.token_id   = cid[0];
	assign out_data.score_bits = csc[0];
	assign out_data.rank_last  = (count_q == 7'd1);
	assign out_data.short_row  = short_q;

	a_no_take_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stks_pkg::ST_DRAIN |-> !in_ready) else $error("input taken in drain");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_q != 7'd0) else $error("drain with empty list");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 7'(N)) else $error("count above capacity");
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the streaming top-k selector.
`timescale 1ns / 1ps
module tb;
	localparam int StallLimit = 5000;
	localparam int DrainGap   = 4;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	stks_pkg::in_beat_t   in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	stks_pkg::out_beat_t  out_data;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [0:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// Selector state as predicted by the testbench
	logic [15:0] pick_score [stks_pkg::MaxK];
	logic [17:0] pick_id [stks_pkg::MaxK];
	int          pick_count = 0;
	logic [17:0] column = '0;
	logic [6:0]  k_reg = 7'd1;

	stks_pkg::out_beat_t winners_q [$];
	int          errors = 0;
	int          logits_sent = 0;
	int          rows_sent = 0;
	int          beats_checked = 0;
	int          idle_cycles = 0;
	int          sink_hold = 0;

	streaming_top_k_select_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Order key: flip negatives, lift positives, so unsigned compare follows value
	function automatic logic [15:0] order_key(input logic [15:0] x);
		if (x[15]) return ~x;
		return {1'b1, x[14:0]};
	endfunction

	function automatic logic exceeds(input logic [15:0] a, input logic [15:0] b);
		if (a[14:0] > 15'h7F80 || b[14:0] > 15'h7F80) return 1'b0;
		if (a[14:0] == 15'd0 && b[14:0] == 15'd0) return 1'b0;
		return order_key(a) > order_key(b);
	endfunction

	// Advance the predicted list by one accepted logit; queue winners on row end
	function automatic void rank_logit(input logic [15:0] v, input logic last);
		int lim;
		int pos;
		stks_pkg::out_beat_t w;
		lim = (k_reg == 0) ? 1 : ((k_reg > stks_pkg::MaxK) ? stks_pkg::MaxK : int'(k_reg));
		if (pick_count > lim) pick_count = lim;
		pos = pick_count;
		for (int i = 0; i < pick_count; i++) begin
			if (exceeds(v, pick_score[i])) begin
				pos = i;
				break;
			end
		end
		if (pos < pick_count || pick_count < lim) begin
			if (pick_count < lim) pick_count++;
			for (int j = pick_count - 1; j > pos; j--) begin
				pick_score[j] = pick_score[j-1];
				pick_id[j] = pick_id[j-1];
			end
			pick_score[pos] = v;
			pick_id[pos] = column;
		end
		column = column + 18'd1;
		if (last) begin
			for (int i = 0; i < pick_count; i++) begin
				w.token_id = pick_id[i];
				w.score_bits = pick_score[i];
				w.rank_last = (i == pick_count - 1);
				w.short_row = (pick_count < lim);
				winners_q = {winners_q, w};
			end
			pick_count = 0;
			column = '0;
		end
	endfunction

	// Offer one beat after a random gap; hold it until taken
	task automatic send_logit(input logic [15:0] v, input logic last);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap > 3 && $urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.logit_bits <= v;
		in_data.row_end <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		rank_logit(v, last);
		logits_sent++;
		if (last) rows_sent++;
	endtask

	// Drop valid, wait for every winner, then let the block settle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (winners_q.size() != 0) @(posedge clk);
		repeat (DrainGap) @(posedge clk);
	endtask

	task automatic write_top_k(input logic [6:0] k);
		logic [24:0] junk;
		junk = 25'($urandom);
		settle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= {junk, k};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		k_reg = k;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_row(input int len, input bit noisy);
		logic [15:0] pool [7];
		logic [15:0] v;
		pool = '{16'h0000, 16'h8000, 16'h3F80, 16'hBF80, 16'h7F80, 16'hFF80, 16'h7FC0};
		for (int i = 0; i < len; i++) begin
			if (noisy || $urandom_range(0, 9) < 7) v = 16'($urandom_range(0, 16'hFFFF));
			else v = pool[$urandom_range(0, 6)];
			send_logit(v, i == len - 1);
		end
	endtask

	// Extremes of the value range: zeros of both signs, infinities, NaNs, ties
	task automatic test_directed();
		logic [15:0] vals [12];
		vals = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'hFFFF,
			16'h7F7F, 16'h0001, 16'h3F80, 16'h3F80, 16'hFF7F, 16'h7F81};
		write_top_k(7'd4);
		foreach (vals[i]) send_logit(vals[i], i == 11);
		write_top_k(7'd8);
		send_logit(16'hC000, 1'b0);
		send_logit(16'h7FC0, 1'b0);
		send_logit(16'h4000, 1'b1);
		write_top_k(7'd1);
		send_logit(16'h7FC0, 1'b0);
		send_logit(16'h3F80, 1'b0);
		send_logit(16'h4000, 1'b1);
		write_top_k(7'd0);
		send_logit(16'h8000, 1'b0);
		send_logit(16'h0000, 1'b0);
		send_logit(16'hBF80, 1'b1);
		write_top_k(7'd64);
		send_logit(16'h1234, 1'b1);
	endtask

	// Saturating limit above the maximum and the full 64-entry list
	task automatic test_k_extremes();
		write_top_k(7'd127);
		send_row(70, 1'b0);
		write_top_k(7'd64);
		send_row(40, 1'b1);
	endtask

	// Lower the limit part-way through a row: the tail must be cut
	task automatic test_midrow_k_change();
		write_top_k(7'd10);
		send_row(0, 1'b0);
		for (int i = 0; i < 8; i++) send_logit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
		write_top_k(7'd3);
		for (int i = 0; i < 4; i++) send_logit(16'($urandom_range(0, 16'hFFFF)), i == 3);
	endtask

	// Hold the sink off for a long stretch while rows keep arriving
	task automatic test_backpressure();
		write_top_k(7'd8);
		sink_hold = 300;
		send_row(10, 1'b0);
		send_row(9, 1'b0);
		send_row(5, 1'b0);
	endtask

	task automatic test_random();
		int budget;
		int k;
		budget = logits_sent + 100;
		while (logits_sent < budget) begin
			if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 127);
			else k = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) write_top_k(7'(k));
			send_row($urandom_range(1, 14), $urandom_range(0, 4) == 0);
		end
	endtask

	// Sink: random stall per beat, optional long hold, check each winner in order
	initial begin : sink
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 2) == 0) gap = 0;
			if (sink_hold > 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (winners_q.size() == 0) begin
				$display("%0t: unexpected winner beat %p", $time, out_data);
				errors++;
			end else begin
				stks_pkg::out_beat_t w;
				w = winners_q.pop_front();
				beats_checked++;
				if (out_data.token_id !== w.token_id) begin
					$display("%0t: token_id expected %0d got %0d", $time, w.token_id,
						out_data.token_id);
					errors++;
				end
				if (out_data.score_bits !== w.score_bits) begin
					$display("%0t: score_bits expected %h got %h", $time, w.score_bits,
						out_data.score_bits);
					errors++;
				end
				if (out_data.rank_last !== w.rank_last) begin
					$display("%0t: rank_last expected %b got %b", $time, w.rank_last,
						out_data.rank_last);
					errors++;
				end
				if (out_data.short_row !== w.short_row) begin
					$display("%0t: short_row expected %b got %b", $time, w.short_row,
						out_data.short_row);
					errors++;
				end
			end
		end
	end

	// Watchdog: any beat on either side resets the idle count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_k_extremes();
		test_midrow_k_change();
		test_backpressure();
		test_random();
		settle();
		repeat (10) @(posedge clk);
		$display("Covered %0d logits in %0d rows, %0d winner beats checked.",
			logits_sent, rows_sent, beats_checked);
		if (errors == 0 && winners_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
sv/stks_pkg.sv
sv/stks_cell.sv
sv/streaming_top_k_select_core.sv
tb/sv/tb.sv
